### rtl/front_middle_back_queue_core_macros.svh
// Assertion macros for the front/middle/back queue core.
`ifndef FRONT_MIDDLE_BACK_QUEUE_CORE_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define FMBQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define FMBQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FMBQ_ASSERT_IMP(lbl, ante, cons, msg)
`define FMBQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/fmbq_pkg.sv
// Shared types, operation codes and constants for the queue core.
`timescale 1ns / 1ps
`default_nettype none
package fmbq_pkg;

	localparam int FMBQ_CAPACITY = 64;

	localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
	localparam logic [2:0] OP_PUSH_MIDDLE = 3'd1;
	localparam logic [2:0] OP_PUSH_BACK   = 3'd2;
	localparam logic [2:0] OP_POP_FRONT   = 3'd3;
	localparam logic [2:0] OP_POP_MIDDLE  = 3'd4;
	localparam logic [2:0] OP_POP_BACK    = 3'd5;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		logic               was_empty;
		logic               was_full;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, work out position
		logic rd;        // read memory at cursor, step cursor
		logic take;      // keep read data as popped value
		logic shift_wr;  // write back last read data one place over
		logic wr_value;  // write pushed value at position
		logic cnt_inc;
		logic cnt_dec;
		logic res_load;  // load output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic push;
		logic full;
		logic empty;
		logic no_shift;
		logic cur_last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

### rtl/fmbq_ctrl.sv
// Sequencing state machine for the queue core.
`timescale 1ns / 1ps
`default_nettype none
module fmbq_ctrl
	import fmbq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire dp_sts_t  sts,
	output dp_cmd_t       cmd
);

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_DECIDE     = 4'd1;
	localparam logic [3:0] ST_PUSH_MOVE  = 4'd2;
	localparam logic [3:0] ST_PUSH_DRAIN = 4'd3;
	localparam logic [3:0] ST_PUSH_WRITE = 4'd4;
	localparam logic [3:0] ST_POP_READ   = 4'd5;
	localparam logic [3:0] ST_POP_TAKE   = 4'd6;
	localparam logic [3:0] ST_POP_MOVE   = 4'd7;
	localparam logic [3:0] ST_POP_DRAIN  = 4'd8;
	localparam logic [3:0] ST_DONE       = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.bad) begin
					state_nxt = ST_DONE;
				end else if (sts.push) begin
					if (sts.full)
						state_nxt = ST_DONE;
					else if (sts.no_shift)
						state_nxt = ST_PUSH_WRITE;
					else
						state_nxt = ST_PUSH_MOVE;
				end else begin
					state_nxt = sts.empty ? ST_DONE : ST_POP_READ;
				end
			end
			ST_PUSH_MOVE: begin
				cmd.rd       = 1'b1;
				cmd.shift_wr = 1'b1;
				if (sts.cur_last)
					state_nxt = ST_PUSH_DRAIN;
			end
			ST_PUSH_DRAIN: begin
				cmd.shift_wr = 1'b1;
				state_nxt    = ST_PUSH_WRITE;
			end
			ST_PUSH_WRITE: begin
				cmd.wr_value = 1'b1;
				cmd.cnt_inc  = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_POP_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_POP_TAKE;
			end
			ST_POP_TAKE: begin
				cmd.take = 1'b1;
				if (sts.no_shift) begin
					cmd.cnt_dec = 1'b1;
					state_nxt   = ST_DONE;
				end else begin
					state_nxt   = ST_POP_MOVE;
				end
			end
			ST_POP_MOVE: begin
				cmd.rd       = 1'b1;
				cmd.shift_wr = 1'b1;
				if (sts.cur_last)
					state_nxt = ST_POP_DRAIN;
			end
			ST_POP_DRAIN: begin
				cmd.shift_wr = 1'b1;
				cmd.cnt_dec  = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule
`default_nettype wire

### rtl/fmbq_dpath.sv
// Element memory, count, cursor and output register for the queue core.
`timescale 1ns / 1ps
`default_nettype none
module fmbq_dpath
	import fmbq_pkg::*;
#(
	parameter int CAPACITY = FMBQ_CAPACITY
)
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire req_t     req,
	input  wire dp_cmd_t  cmd,
	output dp_sts_t       sts,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output rsp_t          rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic [31:0]   mem [CAPACITY];

	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] cursor_q;
	logic [31:0]   value_q;
	logic [31:0]   popped_q;
	logic          bad_q;
	logic          push_q;
	logic          pop_q;
	logic          full_q;
	logic          empty_q;

	logic [31:0]   rdata_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          rd_vld_s1;

	logic [CW-1:0] pos_nxt;
	logic [CW-1:0] count_m1;
	logic          is_push;
	logic          is_pop;
	logic [AW-1:0] shift_addr;

	assign count_m1 = count_q - 1'b1;

	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		pos_nxt = '0;
		case (req.operation) inside
			OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: is_push = 1'b1;
			OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK:    is_pop  = 1'b1;
			default: ;
		endcase
		case (req.operation)
			OP_PUSH_MIDDLE: pos_nxt = count_q >> 1;
			OP_PUSH_BACK:   pos_nxt = count_q;
			OP_POP_MIDDLE:  pos_nxt = count_m1 >> 1;
			OP_POP_BACK:    pos_nxt = count_m1;
			default:        pos_nxt = '0;
		endcase
	end

	// shifted data lands one place behind (push) or ahead (pop) of where it came from
	assign shift_addr = push_q ? (rd_addr_s1 + 1'b1) : (rd_addr_s1 - 1'b1);

	assign sts.bad      = bad_q;
	assign sts.push     = push_q;
	assign sts.full     = full_q;
	assign sts.empty    = empty_q;
	assign sts.no_shift = push_q ? (pos_q == count_q) : (pos_q == count_m1);
	assign sts.cur_last = push_q ? (cursor_q == pos_q) : (cursor_q == count_m1);
	assign sts.out_free = !rsp_valid || !rsp_stall;

	// memory, no reset
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_s1   <= mem[cursor_q[AW-1:0]];
			rd_addr_s1 <= cursor_q[AW-1:0];
		end
		if (cmd.wr_value)
			mem[pos_q[AW-1:0]] <= value_q;
		else if (cmd.shift_wr && rd_vld_s1)
			mem[shift_addr] <= rdata_s1;
	end

	// request payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q  <= req.push_value;
			pos_q    <= pos_nxt;
			cursor_q <= is_push ? count_m1 : pos_nxt;
		end else if (cmd.rd) begin
			cursor_q <= push_q ? (cursor_q - 1'b1) : (cursor_q + 1'b1);
		end
		if (cmd.take)
			popped_q <= rdata_s1;
		if (cmd.res_load) begin
			rsp.pop_value <= (pop_q && empty_q) ? '1 : (pop_q ? popped_q : '0);
			rsp.was_empty <= pop_q && empty_q;
			rsp.was_full  <= push_q && full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			rsp_valid <= 1'b0;
			bad_q     <= 1'b0;
			push_q    <= 1'b0;
			pop_q     <= 1'b0;
			full_q    <= 1'b0;
			empty_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (cmd.load) begin
				bad_q   <= !is_push && !is_pop;
				push_q  <= is_push;
				pop_q   <= is_pop;
				full_q  <= (count_q == CW'(CAPACITY));
				empty_q <= (count_q == '0);
			end
			if (cmd.cnt_inc)
				count_q <= count_q + 1'b1;
			else if (cmd.cnt_dec)
				count_q <= count_m1;
			if (cmd.res_load)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/front_middle_back_queue_core.sv
// Top level of the front/middle/back queue core: controller plus datapath.
// Sequence: dropped pushes, empty pops and spare codes go from the decide state to done;
// a push that moves nothing writes its value, a pop that moves nothing reads and takes it;
// a move steps one element at a time and ends with one drain. Throughput: one request at a
// time; the shift moves one entry per cycle through the memory's single read and write port.
// Reset: arst_n clears the element count, controller and output valid; the memory keeps
// whatever it held and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "front_middle_back_queue_core_macros.svh"
module front_middle_back_queue_core
	import fmbq_pkg::*;
#(
	parameter int CAPACITY = FMBQ_CAPACITY
)
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// command and status between the sequencer and the datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer: takes a request only when idle, walks the shift one element per
	// cycle, then parks in its final state until the output register is free.
	fmbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: element memory (front at entry 0), count, position and cursor,
	// and the output register, which lets a new request in while a result waits.
	fmbq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// a result is never both an empty pop and a full push
	`FMBQ_ASSERT_IMP(a_flags_excl, rsp_valid, !(rsp.was_empty && rsp.was_full), "empty and full both set")
	// an accepted request closes the input until its result is done
	`FMBQ_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall, "input open while busy")
	// output register is only loaded when it is free
	`FMBQ_ASSERT_IMP(a_no_overwrite, cmd.res_load, !rsp_valid || !rsp_stall, "pending result overwritten")
	// only one write into the memory per cycle
	`FMBQ_ASSERT_IMP(a_one_write, cmd.wr_value, !cmd.shift_wr && !cmd.rd, "write port clash")

endmodule
`default_nettype wire
